FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the arcball projection checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define ASP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define ASP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/asp_pkg.sv
// ---------------------------------------------------------------------------
// Arcball projection package
// Register map, widths and fixed-point constants shared by the block.
// ---------------------------------------------------------------------------
package asp_pkg;

	// Configuration register layout.
	localparam int REG_W   = 13;
	localparam int ADDR_W  = 3;
	localparam int APB_W   = 32;

	localparam logic REG_IDX_WIDTH  = 1'b0;
	localparam logic REG_IDX_HEIGHT = 1'b1;

	localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [REG_W-1:0] REG_ONE      = 13'd1;

	// Output formats.
	localparam int VEC_W  = 16;
	localparam int VECZ_W = 15;
	localparam int OUT_FRAC = 15;
	localparam int OUT_DATA_W = 48;

	localparam logic [VEC_W-1:0]  VEC_MAX  = 16'h7FFF;
	localparam logic [VECZ_W-1:0] VECZ_MAX = 15'h7FFF;

endpackage

FILE: sv/asp_div_cell.sv
// ---------------------------------------------------------------------------
// Division cell
// One restoring-division step: shifts in one numerator bit, produces one
// quotient bit and hands the partial result to the next cell.
// ---------------------------------------------------------------------------
module asp_div_cell #(
	parameter int DW = 13,
	parameter int QB = 30,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem_i,
	input  logic [QB-1:0] num_i,
	input  logic [QB-1:0] quo_i,
	input  logic [DW-1:0] den_i,
	input  logic [SW-1:0] side_i,
	output logic [DW-1:0] rem_o,
	output logic [QB-1:0] num_o,
	output logic [QB-1:0] quo_o,
	output logic [DW-1:0] den_o,
	output logic [SW-1:0] side_o
);

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          take;
	logic [DW-1:0] rem_q;
	logic [QB-1:0] num_q;
	logic [QB-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [SW-1:0] side_q;

	// Trial subtraction of the divisor from the widened remainder.
	always_comb begin
		trial = {rem_i, num_i[QB-1]};
		take  = (trial >= {1'b0, den_i});
		diff  = trial - {1'b0, den_i};
	end

	// Partial result moves to the neighbor cell.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? diff[DW-1:0] : trial[DW-1:0];
			num_q  <= {num_i[QB-2:0], 1'b0};
			quo_q  <= {quo_i[QB-2:0], take};
			den_q  <= den_i;
			side_q <= side_i;
		end
	end

	assign rem_o  = rem_q;
	assign num_o  = num_q;
	assign quo_o  = quo_q;
	assign den_o  = den_q;
	assign side_o = side_q;

endmodule

FILE: sv/asp_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Square root cell
// One digit-by-digit square root step: takes two radicand bits and
// resolves one root bit, then hands the partial result onward.
// ---------------------------------------------------------------------------
module asp_sqrt_cell #(
	parameter int RW = 36,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            en,
	input  logic [RW/2+1:0] rem_i,
	input  logic [RW-1:0]   rad_i,
	input  logic [RW/2-1:0] root_i,
	input  logic [SW-1:0]   side_i,
	output logic [RW/2+1:0] rem_o,
	output logic [RW-1:0]   rad_o,
	output logic [RW/2-1:0] root_o,
	output logic [SW-1:0]   side_o
);

	localparam int NB = RW / 2;

	logic [NB+3:0]   cur;
	logic [NB+3:0]   trial;
	logic [NB+3:0]   diff;
	logic            take;
	logic [NB+1:0]   rem_q;
	logic [RW-1:0]   rad_q;
	logic [NB-1:0]   root_q;
	logic [SW-1:0]   side_q;

	// Compare the remainder against 4*root + 1.
	always_comb begin
		cur   = {rem_i, rad_i[RW-1:RW-2]};
		trial = {2'b00, root_i, 2'b01};
		take  = (cur >= trial);
		diff  = cur - trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? diff[NB+1:0] : cur[NB+1:0];
			rad_q  <= {rad_i[RW-3:0], 2'b00};
			root_q <= {root_i[NB-2:0], take};
			side_q <= side_i;
		end
	end

	assign rem_o  = rem_q;
	assign rad_o  = rad_q;
	assign root_o = root_q;
	assign side_o = side_q;

endmodule

FILE: sv/arcball_sphere_projection_unit.sv
// ---------------------------------------------------------------------------
// Arcball sphere projection unit
// Maps a pointer position in pixels to a Q1.15 unit vector on the ball.
// ---------------------------------------------------------------------------
// Usage: pointer requests enter on the s_ channel (pixel_x, pixel_y) and one
// sphere vector leaves on the m_ channel per request, in order. The window
// size is written through the APB port (width at 0x0, height at 0x4) while
// no request is in flight; a size of zero acts as one.
// Throughput: one request per cycle while the receiver keeps up. The row of
// cells holds one division cell per quotient bit of the pixel scaling, one
// square root cell per root bit, and one division cell per bit of the
// normalized components.
// When the receiver stalls, the whole row holds and s_tready drops; the
// finished vector waits in the output register and no request is lost.
// Reset empties the row and loads a 640 x 480 window.
// ---------------------------------------------------------------------------
module arcball_sphere_projection_unit #(
	parameter int COORD_BITS = 14,
	parameter int FRAC_BITS  = 15,
	localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// pixel_x, pixel_y (from bit 0 up), zero padded
	input  logic [IN_W-1:0]           s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// vec_x, vec_y, vec_z (from bit 0 up), zero padded
	output logic [asp_pkg::OUT_DATA_W-1:0] m_tdata,
	// outside_ball
	output logic [0:0]                m_tuser,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [asp_pkg::ADDR_W-1:0] paddr,
	input  logic [asp_pkg::APB_W-1:0] pwdata,
	output logic [asp_pkg::APB_W-1:0] prdata,
	output logic                      pready
);

	localparam int RGW = asp_pkg::REG_W;
	localparam int QB1 = COORD_BITS + FRAC_BITS + 1;
	localparam int VW  = QB1 + 2;
	localparam int AW  = FRAC_BITS + 3;
	localparam int RW  = 2 * AW;
	localparam int NQ  = FRAC_BITS + 1;
	localparam int NST = QB1 + 4 + AW + NQ + 1;
	localparam int SQW = 3 + 2 * AW;
	localparam int NXW = 2 + AW;
	localparam int NYW = 1 + AW;
	localparam int SH_R = (FRAC_BITS > asp_pkg::OUT_FRAC) ? FRAC_BITS - asp_pkg::OUT_FRAC : 0;
	localparam int SH_L = (FRAC_BITS < asp_pkg::OUT_FRAC) ? asp_pkg::OUT_FRAC - FRAC_BITS : 0;
	localparam int MW   = FRAC_BITS + 2 + SH_L;
	localparam logic [MW-1:0] RND = MW'((64'd1 << SH_R) >> 1);
	localparam logic [VW-1:0] ONE_V = VW'(64'd1 << FRAC_BITS);
	localparam logic [VW-1:0] LIM_V = VW'(64'd4 << FRAC_BITS);
	localparam logic [RW-1:0] ONE2  = RW'(1) << (2 * FRAC_BITS);

	// Configuration registers.
	logic [RGW-1:0] width_q;
	logic [RGW-1:0] height_q;
	logic [RGW-1:0] w_eff;
	logic [RGW-1:0] h_eff;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= asp_pkg::WIDTH_RESET;
			height_q <= asp_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				asp_pkg::REG_IDX_WIDTH:  width_q  <= pwdata[RGW-1:0];
				asp_pkg::REG_IDX_HEIGHT: height_q <= pwdata[RGW-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[2])
			asp_pkg::REG_IDX_WIDTH:  prdata = {{(asp_pkg::APB_W-RGW){1'b0}}, width_q};
			asp_pkg::REG_IDX_HEIGHT: prdata = {{(asp_pkg::APB_W-RGW){1'b0}}, height_q};
			default:                 prdata = '0;
		endcase
	end

	assign w_eff = (width_q == '0)  ? asp_pkg::REG_ONE : width_q;
	assign h_eff = (height_q == '0) ? asp_pkg::REG_ONE : height_q;

	// Whole row advances together; the output register frees on take.
	logic           en;
	logic [NST-1:0] vld_q;

	assign en       = !vld_q[NST-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], s_tvalid};
		end
	end

	// Input magnitudes and signs.
	logic [COORD_BITS-1:0] raw_x;
	logic [COORD_BITS-1:0] raw_y;
	logic [COORD_BITS-1:0] mag_x;
	logic [COORD_BITS-1:0] mag_y;

	assign raw_x = s_tdata[COORD_BITS-1:0];
	assign raw_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign mag_x = raw_x[COORD_BITS-1] ? (~raw_x + 1'b1) : raw_x;
	assign mag_y = raw_y[COORD_BITS-1] ? (~raw_y + 1'b1) : raw_y;

	// Pixel scaling: |pixel| * 2^(FRAC_BITS+1) / window size.
	logic [RGW-1:0] sx_rem  [0:QB1];
	logic [QB1-1:0] sx_num  [0:QB1];
	logic [QB1-1:0] sx_quo  [0:QB1];
	logic [RGW-1:0] sx_den  [0:QB1];
	logic [0:0]     sx_side [0:QB1];
	logic [RGW-1:0] sy_rem  [0:QB1];
	logic [QB1-1:0] sy_num  [0:QB1];
	logic [QB1-1:0] sy_quo  [0:QB1];
	logic [RGW-1:0] sy_den  [0:QB1];
	logic [0:0]     sy_side [0:QB1];

	assign sx_rem[0]  = '0;
	assign sx_num[0]  = {mag_x, {(FRAC_BITS+1){1'b0}}};
	assign sx_quo[0]  = '0;
	assign sx_den[0]  = w_eff;
	assign sx_side[0] = raw_x[COORD_BITS-1];
	assign sy_rem[0]  = '0;
	assign sy_num[0]  = {mag_y, {(FRAC_BITS+1){1'b0}}};
	assign sy_quo[0]  = '0;
	assign sy_den[0]  = h_eff;
	assign sy_side[0] = raw_y[COORD_BITS-1];

	for (genvar k = 0; k < QB1; k++) begin : g_scale
		asp_div_cell #(.DW(RGW), .QB(QB1), .SW(1)) u_cell_x (
			.clk    (clk),
			.en     (en),
			.rem_i  (sx_rem[k]),
			.num_i  (sx_num[k]),
			.quo_i  (sx_quo[k]),
			.den_i  (sx_den[k]),
			.side_i (sx_side[k]),
			.rem_o  (sx_rem[k+1]),
			.num_o  (sx_num[k+1]),
			.quo_o  (sx_quo[k+1]),
			.den_o  (sx_den[k+1]),
			.side_o (sx_side[k+1])
		);
		asp_div_cell #(.DW(RGW), .QB(QB1), .SW(1)) u_cell_y (
			.clk    (clk),
			.en     (en),
			.rem_i  (sy_rem[k]),
			.num_i  (sy_num[k]),
			.quo_i  (sy_quo[k]),
			.den_i  (sy_den[k]),
			.side_i (sy_side[k]),
			.rem_o  (sy_rem[k+1]),
			.num_o  (sy_num[k+1]),
			.quo_o  (sy_quo[k+1]),
			.den_o  (sy_den[k+1]),
			.side_o (sy_side[k+1])
		);
	end

	// Floor of the signed quotient, then offset to -1..1 (y flipped).
	logic [VW-1:0] qpos_x, qpos_y, qneg_x, qneg_y, qs_x, qs_y;
	logic [VW-1:0] v_x_s1, v_y_s1;

	always_comb begin
		qpos_x = {2'b00, sx_quo[QB1]};
		qpos_y = {2'b00, sy_quo[QB1]};
		qneg_x = qpos_x + VW'(|sx_rem[QB1]);
		qneg_y = qpos_y + VW'(|sy_rem[QB1]);
		qs_x   = sx_side[QB1][0] ? (~qneg_x + 1'b1) : qpos_x;
		qs_y   = sy_side[QB1][0] ? (~qneg_y + 1'b1) : qpos_y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_x_s1 <= qs_x - ONE_V;
			v_y_s1 <= ONE_V - qs_y;
		end
	end

	// Saturate to +-4 and split into magnitude and sign.
	logic [VW-1:0] abs_x, abs_y;
	logic [AW-1:0] a_x_s2, a_y_s2;
	logic          neg_x_s2, neg_y_s2;

	assign abs_x = v_x_s1[VW-1] ? (~v_x_s1 + 1'b1) : v_x_s1;
	assign abs_y = v_y_s1[VW-1] ? (~v_y_s1 + 1'b1) : v_y_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_x_s2   <= (abs_x > LIM_V) ? LIM_V[AW-1:0] : abs_x[AW-1:0];
			a_y_s2   <= (abs_y > LIM_V) ? LIM_V[AW-1:0] : abs_y[AW-1:0];
			neg_x_s2 <= v_x_s1[VW-1];
			neg_y_s2 <= v_y_s1[VW-1];
		end
	end

	// Squares.
	logic [RW-1:0] sq_x_s3, sq_y_s3;
	logic [AW-1:0] a_x_s3, a_y_s3;
	logic          neg_x_s3, neg_y_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s3  <= a_x_s2 * a_x_s2;
			sq_y_s3  <= a_y_s2 * a_y_s2;
			a_x_s3   <= a_x_s2;
			a_y_s3   <= a_y_s2;
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
		end
	end

	// Radius squared picks the square root argument: 1 - r2 or r2.
	logic [RW-1:0] r2;
	logic          in_c;
	logic [RW-1:0] rad_s4;
	logic [SQW-1:0] side_s4;

	assign r2   = sq_x_s3 + sq_y_s3;
	assign in_c = (r2 <= ONE2);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4  <= in_c ? (ONE2 - r2) : r2;
			side_s4 <= {in_c, neg_x_s3, neg_y_s3, a_x_s3, a_y_s3};
		end
	end

	// Square root row.
	logic [AW+1:0]  sq_rem  [0:AW];
	logic [RW-1:0]  sq_rad  [0:AW];
	logic [AW-1:0]  sq_root [0:AW];
	logic [SQW-1:0] sq_side [0:AW];

	assign sq_rem[0]  = '0;
	assign sq_rad[0]  = rad_s4;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s4;

	for (genvar k = 0; k < AW; k++) begin : g_sqrt
		asp_sqrt_cell #(.RW(RW), .SW(SQW)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (sq_rem[k]),
			.rad_i  (sq_rad[k]),
			.root_i (sq_root[k]),
			.side_i (sq_side[k]),
			.rem_o  (sq_rem[k+1]),
			.rad_o  (sq_rad[k+1]),
			.root_o (sq_root[k+1]),
			.side_o (sq_side[k+1])
		);
	end

	// Normalization row: component * 2^FRAC_BITS / length.
	logic          sq_in, sq_nx, sq_ny;
	logic [AW-1:0] sq_ax, sq_ay;

	assign {sq_in, sq_nx, sq_ny, sq_ax, sq_ay} = sq_side[AW];

	logic [AW-1:0]  nx_rem  [0:NQ];
	logic [NQ-1:0]  nx_num  [0:NQ];
	logic [NQ-1:0]  nx_quo  [0:NQ];
	logic [AW-1:0]  nx_den  [0:NQ];
	logic [NXW-1:0] nx_side [0:NQ];
	logic [AW-1:0]  ny_rem  [0:NQ];
	logic [NQ-1:0]  ny_num  [0:NQ];
	logic [NQ-1:0]  ny_quo  [0:NQ];
	logic [AW-1:0]  ny_den  [0:NQ];
	logic [NYW-1:0] ny_side [0:NQ];

	// The quotient stays below 2^(FRAC_BITS+1), so the upper numerator
	// bits enter as the starting remainder.
	assign nx_rem[0]  = {1'b0, sq_ax[AW-1:1]};
	assign nx_num[0]  = {sq_ax[0], {FRAC_BITS{1'b0}}};
	assign nx_quo[0]  = '0;
	assign nx_den[0]  = sq_root[AW];
	assign nx_side[0] = {sq_in, sq_nx, sq_ax};
	assign ny_rem[0]  = {1'b0, sq_ay[AW-1:1]};
	assign ny_num[0]  = {sq_ay[0], {FRAC_BITS{1'b0}}};
	assign ny_quo[0]  = '0;
	assign ny_den[0]  = sq_root[AW];
	assign ny_side[0] = {sq_ny, sq_ay};

	for (genvar k = 0; k < NQ; k++) begin : g_norm
		asp_div_cell #(.DW(AW), .QB(NQ), .SW(NXW)) u_cell_x (
			.clk    (clk),
			.en     (en),
			.rem_i  (nx_rem[k]),
			.num_i  (nx_num[k]),
			.quo_i  (nx_quo[k]),
			.den_i  (nx_den[k]),
			.side_i (nx_side[k]),
			.rem_o  (nx_rem[k+1]),
			.num_o  (nx_num[k+1]),
			.quo_o  (nx_quo[k+1]),
			.den_o  (nx_den[k+1]),
			.side_o (nx_side[k+1])
		);
		asp_div_cell #(.DW(AW), .QB(NQ), .SW(NYW)) u_cell_y (
			.clk    (clk),
			.en     (en),
			.rem_i  (ny_rem[k]),
			.num_i  (ny_num[k]),
			.quo_i  (ny_quo[k]),
			.den_i  (ny_den[k]),
			.side_i (ny_side[k]),
			.rem_o  (ny_rem[k+1]),
			.num_o  (ny_num[k+1]),
			.quo_o  (ny_quo[k+1]),
			.den_o  (ny_den[k+1]),
			.side_o (ny_side[k+1])
		);
	end

	// Rescale a magnitude of at most 1.0 to 15 fraction bits.
	function automatic logic [asp_pkg::VEC_W-1:0] q15_mag(input logic [FRAC_BITS:0] m);
		logic [MW-1:0] t;
		t = (MW'(m) + RND) >> SH_R;
		t = t << SH_L;
		return t[asp_pkg::VEC_W-1:0];
	endfunction

	// Output selection and conversion.
	logic                      fin_in, fin_nx, fin_ny;
	logic [AW-1:0]             fin_ax, fin_ay;
	logic [FRAC_BITS:0]        mag_ox, mag_oy, mag_oz;
	logic [asp_pkg::VEC_W-1:0] mx, my, mz;
	logic [asp_pkg::VEC_W-1:0] vx, vy;
	logic [asp_pkg::VECZ_W-1:0] vz;

	assign {fin_in, fin_nx, fin_ax} = nx_side[NQ];
	assign {fin_ny, fin_ay}         = ny_side[NQ];

	always_comb begin
		mag_ox = fin_in ? fin_ax[FRAC_BITS:0] : nx_quo[NQ];
		mag_oy = fin_in ? fin_ay[FRAC_BITS:0] : ny_quo[NQ];
		mag_oz = fin_in ? nx_den[NQ][FRAC_BITS:0] : '0;
		mx = q15_mag(mag_ox);
		my = q15_mag(mag_oy);
		mz = q15_mag(mag_oz);
		vx = fin_nx ? (~mx + 1'b1) : (mx[asp_pkg::VEC_W-1] ? asp_pkg::VEC_MAX : mx);
		vy = fin_ny ? (~my + 1'b1) : (my[asp_pkg::VEC_W-1] ? asp_pkg::VEC_MAX : my);
		vz = mz[asp_pkg::VEC_W-1] ? asp_pkg::VECZ_MAX : mz[asp_pkg::VECZ_W-1:0];
	end

	// Output register.
	logic [asp_pkg::VEC_W-1:0]  vec_x_s5, vec_y_s5;
	logic [asp_pkg::VECZ_W-1:0] vec_z_s5;
	logic                       outside_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			vec_x_s5   <= vx;
			vec_y_s5   <= vy;
			vec_z_s5   <= vz;
			outside_s5 <= !fin_in;
		end
	end

	assign m_tdata = {1'b0, vec_z_s5, vec_y_s5, vec_x_s5};
	assign m_tuser = outside_s5;

endmodule

FILE: sv/asp_checker.sv
// ---------------------------------------------------------------------------
// Arcball projection checker
// Port-level checks on the projection unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module asp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [asp_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [0:0]                    m_tuser,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [asp_pkg::ADDR_W-1:0]    paddr,
	input logic [asp_pkg::APB_W-1:0]     pwdata,
	input logic [asp_pkg::APB_W-1:0]     prdata
);

	// A clamped vector lies in the plane.
	`ASP_ASSERT_IMP(a_clamp_z, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[46:32] == 15'd0, "clamped vector has nonzero z")

	// New requests are taken exactly when the output can move.
	`ASP_ASSERT_IMP(a_ready, clk, arst_n, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready disagrees with output state")

	// A stalled vector holds.
	`ASP_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled vector changed")

	// A width write reads back on the next cycle.
	`ASP_ASSERT_NXT(a_readback, clk, arst_n, psel && penable && pwrite && !paddr[2], paddr[2] || prdata[12:0] == $past(pwdata[12:0]), "width register read-back mismatch")

endmodule

bind arcball_sphere_projection_unit asp_checker u_asp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);

FILE: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// Arcball projection testbench
// Streams pointer requests through the projection unit under random idling
// on both sides, predicts every sphere vector in order and compares each
// returned vector field by field. The window size is rewritten between
// phases while the unit is drained.
// ---------------------------------------------------------------------------
module testbench;

	localparam int LATENCY = 69;
	localparam int LIMIT   = 400000;

	typedef struct packed {
		logic signed [13:0] px;
		logic signed [13:0] py;
	} pointer_t;

	typedef struct packed {
		logic [15:0] vx;
		logic [15:0] vy;
		logic [14:0] vz;
		logic        outside;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [asp_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [asp_pkg::ADDR_W-1:0] paddr = '0;
	logic [asp_pkg::APB_W-1:0] pwdata = '0;
	logic [asp_pkg::APB_W-1:0] prdata;
	logic pready;

	pointer_t pending_q[$];
	vector_t  vector_q[$];
	logic [12:0] win_w = asp_pkg::WIDTH_RESET;
	logic [12:0] win_h = asp_pkg::HEIGHT_RESET;
	int errors = 0;
	int cycles = 0;
	int s_idle = 0;
	int m_idle = 0;
	bit calm = 1'b0;

	arcball_sphere_projection_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bit-serial integer square root.
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Scale one axis into -1..1 with a floor division, then clip to +-4.
	function automatic longint scale_clip(longint a, longint d, bit flip);
		longint num, q;
		num = a * 65536;
		if (num >= 0) q = num / d;
		else q = -((-num + d - 1) / d);
		q = q - 32768;
		if (flip) q = -q;
		if (q > 131072) q = 131072;
		if (q < -131072) q = -131072;
		return q;
	endfunction

	function automatic logic [15:0] clip16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic vector_t project(pointer_t p);
		longint w, h, x, y, ax, ay, r2, len, z;
		vector_t v;
		w = (win_w == 0) ? 1 : win_w;
		h = (win_h == 0) ? 1 : win_h;
		x = scale_clip(longint'(p.px), w, 1'b0);
		y = scale_clip(longint'(p.py), h, 1'b1);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		r2 = ax * ax + ay * ay;
		z = 0;
		v.outside = 1'b0;
		if (r2 <= (64'd1 << 30)) begin
			z = int_sqrt((64'd1 << 30) - r2);
		end else begin
			len = int_sqrt(r2);
			x = (x < 0) ? -((ax * 32768) / len) : (ax * 32768) / len;
			y = (y < 0) ? -((ay * 32768) / len) : (ay * 32768) / len;
			v.outside = 1'b1;
		end
		if (z > 32767) z = 32767;
		v.vx = clip16(x);
		v.vy = clip16(y);
		v.vz = z[14:0];
		return v;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// Driver: feeds pending requests, with random idle bursts.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (s_tvalid && s_tready) begin
			vector_q.push_back(project(pending_q.pop_front()));
		end
		if (!(s_tvalid && !s_tready)) begin
			if (s_idle > 0) begin
				s_idle <= s_idle - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				s_idle <= $urandom_range(0, 10);
				s_tvalid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, pending_q[0].py, pending_q[0].px};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: compares each returned vector with the oldest prediction.
	always @(posedge clk) begin
		vector_t want;
		if (m_tvalid && m_tready) begin
			if (vector_q.size() == 0) begin
				report("unexpected vector", 0, 0);
			end else begin
				want = vector_q.pop_front();
				if (m_tdata[15:0] !== want.vx)
					report("vec_x", $signed(m_tdata[15:0]), $signed(want.vx));
				if (m_tdata[31:16] !== want.vy)
					report("vec_y", $signed(m_tdata[31:16]), $signed(want.vy));
				if (m_tdata[46:32] !== want.vz)
					report("vec_z", m_tdata[46:32], want.vz);
				if (m_tuser[0] !== want.outside)
					report("outside_ball", m_tuser[0], want.outside);
			end
		end
		if (m_idle > 0) begin
			m_idle <= m_idle - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			m_idle <= $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Timeout guard.
	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Waits until every request was taken and every vector returned.
	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid) @(posedge clk);
		while (vector_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [12:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= asp_pkg::ADDR_W'(idx) << 2;
		pwdata <= {19'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == asp_pkg::REG_IDX_WIDTH) win_w = value;
		else win_h = value;
	endtask

	task automatic push(int x, int y);
		pointer_t p;
		p.px = x[13:0];
		p.py = y[13:0];
		pending_q.push_back(p);
	endtask

	// Mostly points near the window, some far outside it.
	task automatic push_random(int n);
		int x, y;
		repeat (n) begin
			if ($urandom_range(0, 3) == 0) begin
				x = $urandom;
				y = $urandom;
			end else begin
				x = $urandom_range(0, win_w);
				y = $urandom_range(0, win_h);
			end
			push(x, y);
		end
	endtask

	initial begin
		logic [12:0] sizes[8];
		sizes = '{13'd1, 13'd8191, 13'd0, 13'd640, 13'd2, 13'd100, 13'd4096, 13'd33};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: center, corners, circle edge, far pointers.
		push(320, 240);
		push(0, 0);
		push(640, 480);
		push(0, 240);
		push(640, 240);
		push(320, 0);
		push(8191, 8191);
		push(-8192, -8192);
		push(8191, -8192);
		push(-8192, 8191);
		push(-1, -1);
		push(0, 480);
		push(160, 240);
		drain();

		// Phases over extreme and ordinary window sizes.
		for (int k = 0; k < 8; k++) begin
			write_reg(asp_pkg::REG_IDX_WIDTH, sizes[k]);
			write_reg(asp_pkg::REG_IDX_HEIGHT, sizes[(k + 3) % 8]);
			push(0, 0);
			push(-8192, 8191);
			push(8191, -8192);
			push_random(k == 7 ? 120 : 250);
			if (k == 7) calm = 1'b1;
			drain();
		end

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
